### hdl/pnh_pkg.sv
// ----------------------------------------------------------------------------
// pnh_pkg
// Shared types and constants for the PJW name hash with UTF-8 Latin-1 folding.
// ----------------------------------------------------------------------------
package pnh_pkg;

   localparam int unsigned HashWidth = 32;
   localparam int unsigned ByteWidth = 8;

   localparam logic [ByteWidth-1:0] LeadMask    = 8'hFE;
   localparam logic [ByteWidth-1:0] LeadCode    = 8'hC2;
   localparam logic [ByteWidth-1:0] ContMask    = 8'hC0;
   localparam logic [ByteWidth-1:0] ContCode    = 8'h80;
   localparam logic [ByteWidth-1:0] PayloadMask = 8'h3F;
   localparam logic [HashWidth-1:0] TopMask     = 32'hF000_0000;
   localparam int unsigned          FoldShift   = 24;

   typedef struct packed {
      logic [HashWidth-1:0] running_hash;
      logic                 held_lead_low_bit;
      logic                 lead_held;
   } hash_state_type;

   localparam hash_state_type StateClear = '{
      running_hash:      '0,
      held_lead_low_bit: 1'b0,
      lead_held:         1'b0
   };

endpackage

### hdl/pnh_req_if.sv
// ----------------------------------------------------------------------------
// pnh_req_if
// Request channel: one name byte per transfer with an end-of-name flag.
// ----------------------------------------------------------------------------
interface pnh_req_if import pnh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] name_byte;
   logic                 last_byte;

   modport source (output valid, output name_byte, output last_byte, input ready);
   modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

### hdl/pnh_rsp_if.sv
// ----------------------------------------------------------------------------
// pnh_rsp_if
// Response channel: one finished 32-bit hash per transfer.
// ----------------------------------------------------------------------------
interface pnh_rsp_if import pnh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [HashWidth-1:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

### hdl/pnh_fold_core.sv
// ----------------------------------------------------------------------------
// pnh_fold_core
// One request step: optional UTF-8 pair folding and up to two PJW rounds.
// ----------------------------------------------------------------------------
module pnh_fold_core import pnh_pkg::*; (
   input  hash_state_type       state_cur,
   input  logic [ByteWidth-1:0] name_byte,
   input  logic                 last_byte,
   output hash_state_type       state_nxt,
   output logic [HashWidth-1:0] hash_value
);

   function automatic logic [HashWidth-1:0] pjw_round(
      input logic [HashWidth-1:0] h,
      input logic [ByteWidth-1:0] v
   );
      logic [HashWidth-1:0] t;
      logic [HashWidth-1:0] g;
      begin
         t = {h[HashWidth-5:0], 4'b0000} + {{(HashWidth-ByteWidth){1'b0}}, v};
         g = t & TopMask;
         pjw_round = t ^ (g >> FoldShift) ^ g;
      end
   endfunction

   logic                 is_cont;
   logic                 fresh;
   logic                 hold_new;
   logic [ByteWidth-1:0] first_val;
   logic [HashWidth-1:0] hash_mid;
   logic [HashWidth-1:0] hash_end;

   always_comb begin
      is_cont = (name_byte & ContMask) == ContCode;
      // folded latin-1 value, or the held lead byte on its own
      if (is_cont) begin
         first_val = ContCode | {1'b0, state_cur.held_lead_low_bit, 6'b000000}
                     | (name_byte & PayloadMask);
      end else begin
         first_val = LeadCode | {7'b0000000, state_cur.held_lead_low_bit};
      end
      hash_mid = state_cur.lead_held ? pjw_round(state_cur.running_hash, first_val)
                                     : state_cur.running_hash;
      fresh    = !(state_cur.lead_held && is_cont);
      hold_new = fresh && !last_byte && ((name_byte & LeadMask) == LeadCode);
      hash_end = (fresh && !hold_new) ? pjw_round(hash_mid, name_byte) : hash_mid;

      hash_value = hash_end;
      if (last_byte) begin
         state_nxt = StateClear;
      end else begin
         state_nxt.running_hash      = hash_end;
         state_nxt.held_lead_low_bit = hold_new & name_byte[0];
         state_nxt.lead_held         = hold_new;
      end
   end

endmodule

### hdl/pjw_name_hash_utf8_fold_unit.sv
// ----------------------------------------------------------------------------
// pjw_name_hash_utf8_fold_unit
// PJW name hash, one byte per request, folding C2/C3 UTF-8 pairs to Latin-1.
// ----------------------------------------------------------------------------
// the last byte passes the input register, then the result register, to rsp
// throughput: one request per cycle if rsp keeps up; the input register feeds
//   the hash step and result register; bytes ending no name never wait on rsp
// reset: synchronous, clears both valid flags, the running hash and the
//   held lead byte; no clearing pass
module pjw_name_hash_utf8_fold_unit import pnh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   pnh_req_if.sink   req,
   pnh_rsp_if.source rsp
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;
   hash_state_type       state_ff;
   hash_state_type       state_step;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [HashWidth-1:0] out_hash_ff;
   logic [HashWidth-1:0] hash_step;
   logic                 step_go;

   pnh_fold_core u_core (
      .state_cur  (state_ff),
      .name_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .state_nxt  (state_step),
      .hash_value (hash_step)
   );

   // a byte that ends no name does not need the result register
   assign step_go   = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || step_go;

   always_comb begin
      in_valid_in  = req.valid ? 1'b1 : (in_valid_ff && !step_go);
      out_valid_in = out_valid_ff && !rsp.ready;
      if (step_go && in_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= StateClear;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_go) begin
            state_ff <= state_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.name_byte;
         in_last_ff <= req.last_byte;
      end
      if (step_go && in_last_ff) begin
         out_hash_ff <= hash_step;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.hash_value = out_hash_ff;

endmodule

### test/pjw_name_hash_utf8_fold_unit_test.sv
// ----------------------------------------------------------------------------
// pjw_name_hash_utf8_fold_unit_test
// Drives name bytes into the PJW name hash and checks every finished hash
// against a typed value or a local model of C2/C3 UTF-8 to Latin-1 folding.
// A short table of hand-picked names comes first, then random names under
// several mixes of sender gaps and receiver stalls, plus one long rsp hold.
// ----------------------------------------------------------------------------
module pjw_name_hash_utf8_fold_unit_test;
   import pnh_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [ByteWidth-1:0] name_byte;
      logic                 last_byte;
      logic                 typed;
      logic [HashWidth-1:0] hash_value;
   } name_row_type;

   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   localparam int unsigned DirectedCount = 24;
   localparam int unsigned QuietLimit    = 2000;
   localparam int unsigned HoldCycles    = 300;
   localparam int unsigned PhaseBytes    = 400;

   localparam name_row_type DirectedRows [DirectedCount] = '{
      '{8'h00, 1'b1, TYPED,     32'h0000_0000},
      '{8'hFF, 1'b1, TYPED,     32'h0000_00FF},
      '{8'h80, 1'b1, TYPED,     32'h0000_0080},
      // lead byte in the last position hashes as itself
      '{8'hC2, 1'b1, TYPED,     32'h0000_00C2},
      '{8'hC3, 1'b1, TYPED,     32'h0000_00C3},
      // folded pairs ending on the last byte
      '{8'hC3, 1'b0, PREDICTED, 32'h0},
      '{8'hA9, 1'b1, TYPED,     32'h0000_00E9},
      '{8'hC2, 1'b0, PREDICTED, 32'h0},
      '{8'h80, 1'b1, TYPED,     32'h0000_0080},
      // held lead then plain byte
      '{8'hC2, 1'b0, PREDICTED, 32'h0},
      '{8'h41, 1'b1, PREDICTED, 32'h0},
      // held lead then another lead, which is held in turn
      '{8'hC3, 1'b0, PREDICTED, 32'h0},
      '{8'hC2, 1'b0, PREDICTED, 32'h0},
      '{8'hBF, 1'b1, PREDICTED, 32'h0},
      '{8'hC2, 1'b0, PREDICTED, 32'h0},
      '{8'hC3, 1'b1, PREDICTED, 32'h0},
      // long run so the top nibble folds back
      '{8'hFF, 1'b0, PREDICTED, 32'h0},
      '{8'hFF, 1'b0, PREDICTED, 32'h0},
      '{8'hFF, 1'b0, PREDICTED, 32'h0},
      '{8'hFF, 1'b0, PREDICTED, 32'h0},
      '{8'hFF, 1'b0, PREDICTED, 32'h0},
      '{8'hFF, 1'b0, PREDICTED, 32'h0},
      '{8'hFF, 1'b0, PREDICTED, 32'h0},
      '{8'hFF, 1'b1, PREDICTED, 32'h0}
   };

   logic clock = 1'b0;
   logic reset;

   pnh_req_if req_ch ();
   pnh_rsp_if rsp_ch ();

   pjw_name_hash_utf8_fold_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // carried next to the request so the monitor knows a typed-in hash
   logic                 req_typed;
   logic [HashWidth-1:0] req_typed_hash;

   hash_state_type       model_state;
   logic [HashWidth-1:0] pending_hashes [$];
   idle_mode_type        idle_mode;
   bit                   hold_pending;
   int unsigned          hold_left;
   int unsigned          error_count;
   int unsigned          bytes_accepted;
   int unsigned          hashes_checked;
   int unsigned          input_stalls;
   int unsigned          quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [HashWidth-1:0] pjw_mix(input logic [HashWidth-1:0] h,
                                                    input logic [ByteWidth-1:0] v);
      logic [HashWidth-1:0] t;
      logic [HashWidth-1:0] top;
      t = (h << 4) + {{(HashWidth-ByteWidth){1'b0}}, v};
      top = t & TopMask;
      if (top != '0) begin
         t = t ^ (top >> FoldShift);
         t = t ^ top;
      end
      return t;
   endfunction

   // advances the model by one name byte, returns 1 when a hash is due
   function automatic bit hash_name_byte(input logic [ByteWidth-1:0] b, input logic last,
                                         output logic [HashWidth-1:0] hash);
      bit fresh;
      fresh = 1'b1;
      hash = '0;
      if (model_state.lead_held) begin
         if ((b & ContMask) == ContCode) begin
            model_state.running_hash = pjw_mix(model_state.running_hash,
               ContCode | {1'b0, model_state.held_lead_low_bit, 6'b0} | (b & PayloadMask));
            fresh = 1'b0;
         end else begin
            model_state.running_hash = pjw_mix(model_state.running_hash,
               LeadCode | {7'b0, model_state.held_lead_low_bit});
         end
         model_state.lead_held = 1'b0;
         model_state.held_lead_low_bit = 1'b0;
      end
      if (fresh) begin
         if (!last && (b & LeadMask) == LeadCode) begin
            model_state.lead_held = 1'b1;
            model_state.held_lead_low_bit = b[0];
         end else begin
            model_state.running_hash = pjw_mix(model_state.running_hash, b);
         end
      end
      if (last) begin
         hash = model_state.running_hash;
         model_state = StateClear;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [HashWidth-1:0] got,
                                  input logic [HashWidth-1:0] want);
      $display("mismatch: %s: got %08h, expected %08h", what, got, want);
      error_count++;
   endtask

   // monitor: request side first so a same-edge hash always finds its entry
   always @(posedge clock) begin
      logic [HashWidth-1:0] predicted;
      logic [HashWidth-1:0] want;
      bit                   moved;
      if (reset) begin
         model_state = StateClear;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            bytes_accepted++;
            if (hash_name_byte(req_ch.name_byte, req_ch.last_byte, predicted))
               pending_hashes.push_back(req_typed ? req_typed_hash : predicted);
         end else if (req_ch.valid) begin
            input_stalls++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (pending_hashes.size() == 0) begin
               report_mismatch("hash with no name pending", rsp_ch.hash_value, '0);
            end else begin
               want = pending_hashes.pop_front();
               hashes_checked++;
               if (rsp_ch.hash_value !== want)
                  report_mismatch("hash_value", rsp_ch.hash_value, want);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver: random stalls by mode, plus the long hold on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (idle_mode)
               IDLE_RECEIVER: rsp_ch.ready <= ($urandom_range(99) >= 74);
               IDLE_BOTH:     rsp_ch.ready <= ($urandom_range(99) >= 14);
               default:       rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   // called at a rising edge; returns at a rising edge after the request went in
   task automatic send_request(input logic [ByteWidth-1:0] b, input logic last,
                               input logic typed, input logic [HashWidth-1:0] typed_hash);
      int unsigned gap_pct;
      req_ch.valid <= 1'b1;
      req_ch.name_byte <= b;
      req_ch.last_byte <= last;
      req_typed <= typed;
      req_typed_hash <= typed_hash;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap_pct = (idle_mode == IDLE_SENDER) ? 74 : (idle_mode == IDLE_BOTH) ? 14 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // random name, mostly well-formed text with C2/C3 pairs, some stray bytes
   task automatic send_name(input int unsigned len);
      int unsigned          i;
      int unsigned          pick;
      logic [ByteWidth-1:0] b;
      i = 0;
      while (i < len) begin
         pick = $urandom_range(99);
         if (pick < 30 && len - i >= 2) begin
            send_request(LeadCode | ByteWidth'($urandom_range(1)), 1'b0, PREDICTED, '0);
            send_request(ContCode | ByteWidth'($urandom_range(63)), (len - i == 2),
                         PREDICTED, '0);
            i += 2;
         end else begin
            if (pick < 70)      b = ByteWidth'($urandom_range(127));
            else if (pick < 80) b = LeadCode | ByteWidth'($urandom_range(1));
            else if (pick < 90) b = ContCode | ByteWidth'($urandom_range(63));
            else                b = ByteWidth'($urandom_range(255));
            send_request(b, (i == len - 1), PREDICTED, '0);
            i++;
         end
      end
   endtask

   task automatic send_random_names(input idle_mode_type mode, input int unsigned byte_goal);
      int unsigned start;
      int unsigned len;
      idle_mode = mode;
      start = bytes_accepted;
      while (bytes_accepted - start < byte_goal) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         send_name(len);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.name_byte <= '0;
      req_ch.last_byte <= 1'b0;
      req_typed <= PREDICTED;
      req_typed_hash <= '0;
      idle_mode = IDLE_NONE;
      hold_pending = 1'b0;
      hold_left = 0;
      error_count = 0;
      bytes_accepted = 0;
      hashes_checked = 0;
      input_stalls = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DirectedCount; r++)
         send_request(DirectedRows[r].name_byte, DirectedRows[r].last_byte,
                      DirectedRows[r].typed, DirectedRows[r].hash_value);

      send_random_names(IDLE_NONE, PhaseBytes);
      send_random_names(IDLE_SENDER, PhaseBytes);
      send_random_names(IDLE_RECEIVER, PhaseBytes);
      send_random_names(IDLE_BOTH, PhaseBytes);

      // long rsp hold while short names keep coming, to back up the input
      idle_mode = IDLE_NONE;
      hold_pending = 1'b1;
      for (int n = 0; n < 100; n++)
         send_name($urandom_range(1, 2));

      req_ch.valid <= 1'b0;
      idle_mode = IDLE_NONE;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d hashes over %0d name bytes", hashes_checked, bytes_accepted);
      $display("directed names, random text in four gap/stall mixes, %0d stalled requests",
               input_stalls);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
